>>> rtl/sobel_edge_rgb_stream_top_defines.svh
// Assertion macros for the Sobel edge stream block
`ifndef SOBEL_EDGE_RGB_STREAM_TOP_DEFINES_SVH
`define SOBEL_EDGE_RGB_STREAM_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// implication checked every edge outside reset
`define SES_ASSERT_IMP(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
	else $error("assertion failed");
// implication checked in the next cycle
`define SES_ASSERT_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
	else $error("assertion failed");
`else
`define SES_ASSERT_IMP(label, a, c)
`define SES_ASSERT_NEXT(label, a, c)
`endif
`endif

>>> rtl/ses_pkg.sv
// Shared types and constants for the Sobel edge stream block
`timescale 1ns / 1ps
package ses_pkg;
	localparam int unsigned PIX_W = 24;
	localparam int unsigned FW_W = 11;
	localparam int unsigned FH_W = 12;
	localparam logic [FW_W-1:0] FW_RESET = 11'd640;
	localparam logic [FH_W-1:0] FH_RESET = 12'd480;
	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;
	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       action;
	} in_word_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       frame_end;
	} out_word_t;

	// controller to datapath
	typedef struct packed {
		logic take;       // accept an input word this cycle
		logic restart;    // clear counters
		logic compute;    // start computing one result
	} ses_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic result_ready; // the next result has all its inputs
		logic done;         // result registered this cycle
	} ses_sts_t;
endpackage

>>> rtl/ses_stream_if.sv
// Valid/ready stream channel
`timescale 1ns / 1ps
interface ses_stream_if #(parameter int unsigned W = 25);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/ses_datapath.sv
// Line stores, window fetch and Sobel magnitude datapath
`timescale 1ns / 1ps
module ses_datapath #(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ses_pkg::ses_cmd_t        cmd,
	output ses_pkg::ses_sts_t        sts,
	input  ses_pkg::in_word_t        in_word,
	input  logic [ses_pkg::FW_W-1:0] frame_width,
	input  logic [ses_pkg::FH_W-1:0] frame_height,
	output ses_pkg::out_word_t       out_word
);
	localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned XW = CW + 1;
	localparam int unsigned RW = ses_pkg::FH_W;
	localparam logic [3:0] STEP_LAND = 4'd3;  // last column lands in the window
	localparam logic [3:0] STEP_NORM = 4'd4;  // squared norms formed
	localparam logic [3:0] STEP_LAST = 4'd12; // last root bit

	// effective size
	logic [XW-1:0] w;
	logic [RW-1:0] h;
	always_comb begin
		if (frame_width == '0) w = XW'(1);
		else if (32'(frame_width) > MAX_WIDTH) w = XW'(MAX_WIDTH);
		else w = XW'(frame_width);
		h = (frame_height == '0) ? RW'(1) : frame_height;
	end

	// four row buffers, row r kept in bank r mod 4; a pending result at the
	// end of a row may still need the row that lies three rows above the input
	logic [ses_pkg::PIX_W-1:0] bank0 [MAX_WIDTH];
	logic [ses_pkg::PIX_W-1:0] bank1 [MAX_WIDTH];
	logic [ses_pkg::PIX_W-1:0] bank2 [MAX_WIDTH];
	logic [ses_pkg::PIX_W-1:0] bank3 [MAX_WIDTH];

	logic [CW-1:0] in_col_q;
	logic [RW-1:0] in_row_q;
	logic [1:0]    in_bank_q;
	logic          in_done_q;
	logic [CW-1:0] out_col_q;
	logic [RW-1:0] out_row_q;
	logic [1:0]    out_bank_q;

	logic writing;
	assign writing = cmd.take && (in_word.action == ses_pkg::ACT_PIXEL) && !in_done_q;

	always_ff @(posedge clk) begin
		if (writing) begin
			case (in_bank_q)
				2'd0: bank0[in_col_q] <= {in_word.red, in_word.green, in_word.blue};
				2'd1: bank1[in_col_q] <= {in_word.red, in_word.green, in_word.blue};
				2'd2: bank2[in_col_q] <= {in_word.red, in_word.green, in_word.blue};
				default: bank3[in_col_q] <= {in_word.red, in_word.green, in_word.blue};
			endcase
		end
	end

	// readiness: needed pixel (nr, nc) already received
	logic [RW-1:0] nr;
	logic [XW-1:0] nc;
	logic          rdy;
	always_comb begin
		nr = (32'(out_row_q) + 1 < 32'(h)) ? out_row_q + RW'(1) : h - RW'(1);
		nc = (32'(out_col_q) + 1 < 32'(w)) ? XW'(out_col_q) + XW'(1) : w - XW'(1);
		if (in_done_q) rdy = 1'b1;
		else rdy = (nr < in_row_q) || ((nr == in_row_q) && (nc < XW'(in_col_q)));
	end

	// result sequencer: steps 0..2 read one column of three each, step 3 lands
	// the last column, step 4 forms the squared norms, 5..12 give one root bit each
	logic       busy_q;
	logic [3:0] step_q;
	logic       calc_q;
	logic [ses_pkg::PIX_W-1:0] win_q [9];
	logic [2:0] rdv_q;    // valid (in frame) per row of read
	logic [1:0] rdc_q;    // column slot of read data
	logic       rdp_q;    // read data pending

	logic [XW:0]   fc;    // column being fetched, may be -1 or w
	logic          col_ok;
	logic [CW-1:0] fidx;
	always_comb begin
		fc = {1'b0, XW'(out_col_q)} + (XW+1)'(step_q) - (XW+1)'(1);
		col_ok = !fc[XW] && (fc[XW-1:0] < w);
		fidx = fc[CW-1:0];
	end

	function automatic logic [ses_pkg::PIX_W-1:0] bank_rd(input logic [1:0] b,
			input logic [ses_pkg::PIX_W-1:0] a0, input logic [ses_pkg::PIX_W-1:0] a1,
			input logic [ses_pkg::PIX_W-1:0] a2, input logic [ses_pkg::PIX_W-1:0] a3);
		case (b)
			2'd0: return a0;
			2'd1: return a1;
			2'd2: return a2;
			default: return a3;
		endcase
	endfunction

	logic [1:0] up_bank, dn_bank;
	assign up_bank = out_bank_q - 2'd1;
	assign dn_bank = out_bank_q + 2'd1;

	logic [ses_pkg::PIX_W-1:0] m0_q, m1_q, m2_q, m3_q;
	always_ff @(posedge clk) begin
		m0_q <= bank0[fidx];
		m1_q <= bank1[fidx];
		m2_q <= bank2[fidx];
		m3_q <= bank3[fidx];
	end
	logic [1:0] ub_q, mb_q, db_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; step_q <= '0; calc_q <= 1'b0; rdp_q <= 1'b0;
		end else begin
			calc_q <= 1'b0;
			rdp_q <= 1'b0;
			if (cmd.compute && !busy_q) begin
				busy_q <= 1'b1; step_q <= '0;
			end else if (busy_q) begin
				if (step_q < STEP_LAND) rdp_q <= 1'b1;
				if (step_q == STEP_LAST) begin
					busy_q <= 1'b0; calc_q <= 1'b1;
				end else begin
					step_q <= step_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && step_q < STEP_LAND) begin
			rdc_q <= step_q[1:0];
			rdv_q[0] <= col_ok && (out_row_q != '0);
			rdv_q[1] <= col_ok;
			rdv_q[2] <= col_ok && (32'(out_row_q) + 1 < 32'(h));
			ub_q <= up_bank; mb_q <= out_bank_q; db_q <= dn_bank;
		end
		if (rdp_q) begin
			win_q[{2'd0, rdc_q}] <= rdv_q[0] ? bank_rd(ub_q, m0_q, m1_q, m2_q, m3_q) : '0;
			win_q[4'(rdc_q) + 4'd3] <= rdv_q[1] ? bank_rd(mb_q, m0_q, m1_q, m2_q, m3_q) : '0;
			win_q[4'(rdc_q) + 4'd6] <= rdv_q[2] ? bank_rd(db_q, m0_q, m1_q, m2_q, m3_q) : '0;
		end
	end

	// gradient and squared norm per channel
	logic [23:0] norm [3];
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			logic signed [23:0] p [9];
			logic signed [23:0] gx, gy;
			for (int i = 0; i < 9; i++) p[i] = $signed({16'd0, win_q[i][8*(2-ch) +: 8]});
			gx = (p[2] + (p[5] <<< 1) + p[8]) - (p[0] + (p[3] <<< 1) + p[6]);
			gy = (p[6] + (p[7] <<< 1) + p[8]) - (p[0] + (p[1] <<< 1) + p[2]);
			norm[ch] = 24'(gx * gx) + 24'(gy * gy);
		end
	end

	// floor square root, one bit a step from the top
	logic [15:0] sq_q [3];
	logic [2:0]  sat_q;
	logic [7:0]  root_q [3];
	logic [2:0]  bit_sel;
	logic [7:0]  trial [3];
	always_comb begin
		bit_sel = 3'(STEP_LAST - step_q);
		for (int ch = 0; ch < 3; ch++) trial[ch] = root_q[ch] | (8'd1 << bit_sel);
	end

	always_ff @(posedge clk) begin
		if (busy_q && step_q == STEP_NORM) begin
			for (int ch = 0; ch < 3; ch++) begin
				sq_q[ch] <= norm[ch][15:0];
				sat_q[ch] <= (norm[ch][23:16] != 8'd0);
				root_q[ch] <= '0;
			end
		end else if (busy_q && step_q > STEP_NORM) begin
			for (int ch = 0; ch < 3; ch++) begin
				if ({8'd0, trial[ch]} * {8'd0, trial[ch]} <= sq_q[ch]) root_q[ch] <= trial[ch];
			end
		end
	end

	logic last;
	assign last = (out_row_q == h - RW'(1)) && (XW'(out_col_q) == w - XW'(1));

	always_ff @(posedge clk) begin
		if (calc_q) begin
			out_word.red <= sat_q[0] ? 8'd255 : root_q[0];
			out_word.green <= sat_q[1] ? 8'd255 : root_q[1];
			out_word.blue <= sat_q[2] ? 8'd255 : root_q[2];
			out_word.frame_end <= last;
		end
	end

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q <= '0; in_row_q <= '0; in_bank_q <= '0; in_done_q <= 1'b0;
			out_col_q <= '0; out_row_q <= '0; out_bank_q <= '0;
		end else if (cmd.restart) begin
			in_col_q <= '0; in_row_q <= '0; in_bank_q <= '0; in_done_q <= 1'b0;
			out_col_q <= '0; out_row_q <= '0; out_bank_q <= '0;
		end else begin
			if (writing) begin
				if (XW'(in_col_q) + XW'(1) >= w) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + RW'(1);
					in_bank_q <= in_bank_q + 2'd1;
					if (in_row_q + RW'(1) >= h) in_done_q <= 1'b1;
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
			end
			if (calc_q) begin
				if (last) begin
					in_col_q <= '0; in_row_q <= '0; in_bank_q <= '0; in_done_q <= 1'b0;
					out_col_q <= '0; out_row_q <= '0; out_bank_q <= '0;
				end else if (XW'(out_col_q) + XW'(1) >= w) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + RW'(1);
					out_bank_q <= out_bank_q + 2'd1;
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
		end
	end

	assign sts.result_ready = rdy;
	assign sts.done = calc_q;
endmodule

>>> rtl/ses_ctrl.sv
// Controller: input acceptance and result sequencing
`timescale 1ns / 1ps
module ses_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  logic              cfg_we,
	input  ses_pkg::ses_sts_t sts,
	output ses_pkg::ses_cmd_t cmd
);
	typedef enum logic [1:0] {IDLE, CHECK, BUSY} state_t;
	state_t state_q;

	// one word at a time: accept, check readiness, compute, then free
	assign in_ready = (state_q == IDLE) && !out_valid && !cfg_we;
	assign cmd.take = in_valid && in_ready;
	assign cmd.restart = cfg_we;
	assign cmd.compute = (state_q == CHECK) && sts.result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				IDLE: if (cmd.take) state_q <= CHECK;
				CHECK: state_q <= sts.result_ready ? BUSY : IDLE;
				BUSY: if (sts.done) begin
					state_q <= IDLE;
					out_valid <= 1'b1;
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

>>> rtl/sobel_edge_rgb_stream_top.sv
// Top level of the RGB Sobel edge stream block
// Usage:
//  Pixels enter on in_ch in raster order; action=1 words drain pending
//  results after the frame's last pixel. Each input word yields at most one
//  output word on out_ch (three 8-bit gradient magnitudes and frame_end).
//  Frame size comes from the cfg port (index 0 width, 1 height); a write
//  restarts the frame.
//  Each accepted word is checked for readiness; a word that yields a result
//  is followed by the window fetch (three column reads from four line
//  buffers), the squared norms and eight square root steps, and no new word
//  is accepted until its result is registered. A word that yields none
//  frees the input again after the readiness check.
//  Reset clears counters and size registers (640x480); line buffers are
//  not cleared and need none.
//  When the receiver stalls the result stays in the output register and
//  no new word is accepted until it is taken.
`timescale 1ns / 1ps
`include "sobel_edge_rgb_stream_top_defines.svh"
module sobel_edge_rgb_stream_top #(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic clk,
	input  logic arst_n,
	ses_stream_if.sink   in_ch,
	ses_stream_if.source out_ch,
	input  logic                    cfg_we,
	input  logic                    cfg_index,
	input  logic [ses_pkg::FH_W-1:0] cfg_wdata
);
	logic [ses_pkg::FW_W-1:0] frame_width_q;
	logic [ses_pkg::FH_W-1:0] frame_height_q;
	ses_pkg::ses_cmd_t  cmd;
	ses_pkg::ses_sts_t  sts;
	ses_pkg::out_word_t ow;

	// size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= ses_pkg::FW_RESET;
			frame_height_q <= ses_pkg::FH_RESET;
		end else if (cfg_we) begin
			if (cfg_index == ses_pkg::REG_WIDTH) frame_width_q <= cfg_wdata[ses_pkg::FW_W-1:0];
			else frame_height_q <= cfg_wdata;
		end
	end

	ses_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.cfg_we(cfg_we), .sts(sts), .cmd(cmd)
	);

	ses_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_word(ses_pkg::in_word_t'(in_ch.data)),
		.frame_width(frame_width_q), .frame_height(frame_height_q),
		.out_word(ow)
	);
	assign out_ch.data = ow;

	`SES_ASSERT_IMP(a_no_take_while_full, out_ch.valid, !in_ch.ready)
	`SES_ASSERT_NEXT(a_done_sets_valid, sts.done, out_ch.valid)
	`SES_ASSERT_IMP(a_no_take_on_cfg, cfg_we, !cmd.take)
endmodule
